// File: src/gwdp_pkg.sv
// ----------------------------------------------------------------------------
// gwdp_pkg
// Shared constants for the gapped window difference peak filter.
// ----------------------------------------------------------------------------
package gwdp_pkg;

	// converter sample width
	localparam int SAMPLE_BITS = 16;

	// result field width
	localparam int OUT_W = 25;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_POLARITY = 2'd2;

	localparam logic [7:0] WINDOW_LEN_RST      = 8'd50;
	localparam logic [7:0] GAP_LEN_RST         = 8'd1;
	localparam logic       INVERT_POLARITY_RST = 1'b1;

	// per-pulse sample count, saturating
	localparam int             COUNT_W   = 10;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

endpackage

// File: src/gwdp_in_if.sv
// ----------------------------------------------------------------------------
// gwdp_in_if
// Sample channel: valid/ready handshake with one sample and its end-of-pulse flag.
// ----------------------------------------------------------------------------
interface gwdp_in_if
	import gwdp_pkg::*;
;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          pulse_end;

	modport source (output valid, output sample, output pulse_end, input ready);
	modport sink (input valid, input sample, input pulse_end, output ready);
endinterface

// File: src/gwdp_out_if.sv
// ----------------------------------------------------------------------------
// gwdp_out_if
// Result channel: filter value, pulse peak and their flags.
// ----------------------------------------------------------------------------
interface gwdp_out_if
	import gwdp_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filter_value;
	logic                    filter_valid;
	logic signed [OUT_W-1:0] pulse_peak;
	logic                    peak_valid;
	logic                    is_last;

	modport source (
		output valid, output filter_value, output filter_valid,
		output pulse_peak, output peak_valid, output is_last, input ready
	);
	modport sink (
		input valid, input filter_value, input filter_valid,
		input pulse_peak, input peak_valid, input is_last, output ready
	);
endinterface

// File: src/gapped_window_difference_peak.sv
// ----------------------------------------------------------------------------
// gapped_window_difference_peak
// Trapezoidal energy filter: gapped two-window difference with per-pulse peak.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the result channel does not stall. A
// sample passes three registers: the input stage (polarity, count, ring
// pointers), the ring read stage (three copies of the sample ring, one read
// each) and the sum stage, which updates both window sums and the peak and
// loads the result register, which drives dout. A result is given once a span of
// 2*window_len+gap_len+1 samples is filled, and always for the sample
// flagged pulse_end, which also carries the pulse peak and restarts the
// pulse. A write to any of the three configuration registers also restarts
// the pulse; write only while no sample is in flight. Spans longer than
// RING_DEPTH-1 read aliased entries.
// ----------------------------------------------------------------------------
module gapped_window_difference_peak
	import gwdp_pkg::*;
#(
	parameter int RING_DEPTH  = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	gwdp_in_if.sink               din,
	gwdp_out_if.source            dout
);

	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int SUM_W  = SAMPLE_BITS + 8;
	localparam int DIFF_W = SUM_W + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef struct packed {
		logic far_sub;
		logic near_add;
		logic near_sub;
		logic full;
	} flags_t;

	function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [7:0] window_len_q;
	logic [7:0] gap_len_q;
	logic       invert_q;

	// input stage state
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  wp_q, rp_fs_q, rp_na_q, rp_ns_q;

	// pipeline
	logic                          v1_q, v2_q, vo_q;
	logic signed [SAMPLE_BITS-1:0] x_s1, x_s2;
	logic                          last_s1, last_s2;
	flags_t                        flags_s1, flags_s2;
	logic [ADDR_W-1:0]             wa_s1, ra_fs_s1, ra_na_s1, ra_ns_s1;
	logic signed [SAMPLE_BITS-1:0] rd_fs, rd_na, rd_ns;

	// sum stage state
	logic signed [SUM_W-1:0]  far_sum_q, near_sum_q;
	logic signed [DIFF_W-1:0] peak_q;
	logic                     have_peak_q;

	// result register
	logic signed [OUT_W-1:0] filter_value_q, pulse_peak_q;
	logic                    filter_valid_q, peak_valid_q, is_last_q;

	// handshake
	logic accept, adv1, adv2, res2, o_free, s2_free;

	assign o_free  = !vo_q || dout.ready;
	assign res2    = flags_s2.full || last_s2;
	assign adv2    = v2_q && (!res2 || o_free);
	assign s2_free = !v2_q || adv2;
	assign adv1    = v1_q && s2_free;
	assign din.ready = !v1_q || adv1;
	assign accept  = din.valid && din.ready;

	// ---------------- input stage ----------------
	logic [COUNT_W-1:0]            thr_fs, thr_na, thr_full, thr_ns;
	flags_t                        flags_in;
	logic signed [SAMPLE_BITS-1:0] x_in;

	always_comb begin
		thr_fs   = COUNT_W'(window_len_q) + 1'b1;
		thr_na   = COUNT_W'(window_len_q) + COUNT_W'(gap_len_q);
		thr_full = (COUNT_W'(window_len_q) << 1) + COUNT_W'(gap_len_q);
		thr_ns   = thr_full + 1'b1;
		flags_in.far_sub  = count_q >= thr_fs;
		flags_in.near_add = count_q >= thr_na;
		flags_in.near_sub = count_q >= thr_ns;
		flags_in.full     = count_q >= thr_full;
		if (!invert_q) begin
			x_in = din.sample;
		end else if (din.sample == S_MIN) begin
			x_in = S_MAX;
		end else begin
			x_in = -din.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			gap_len_q    <= GAP_LEN_RST;
			invert_q     <= INVERT_POLARITY_RST;
			count_q      <= '0;
			wp_q         <= '0;
			rp_fs_q      <= '0;
			rp_na_q      <= '0;
			rp_ns_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LEN:      window_len_q <= cfg_data;
				REG_GAP_LEN:         gap_len_q    <= cfg_data;
				REG_INVERT_POLARITY: invert_q     <= cfg_data[0];
				default: ;
			endcase
			if (cfg_index == REG_WINDOW_LEN || cfg_index == REG_GAP_LEN
					|| cfg_index == REG_INVERT_POLARITY) begin
				count_q <= '0;
				wp_q    <= '0;
				rp_fs_q <= '0;
				rp_na_q <= '0;
				rp_ns_q <= '0;
			end
		end else if (accept) begin
			if (din.pulse_end) begin
				count_q <= '0;
				wp_q    <= '0;
				rp_fs_q <= '0;
				rp_na_q <= '0;
				rp_ns_q <= '0;
			end else begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
				// a read pointer starts at entry 0 the first time its distance is reached
				wp_q <= ptr_inc(wp_q);
				if (flags_in.far_sub)  rp_fs_q <= ptr_inc(rp_fs_q);
				if (flags_in.near_add) rp_na_q <= ptr_inc(rp_na_q);
				if (flags_in.near_sub) rp_ns_q <= ptr_inc(rp_ns_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (accept) begin
			v1_q <= 1'b1;
		end else if (adv1) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= x_in;
			last_s1  <= din.pulse_end;
			flags_s1 <= flags_in;
			wa_s1    <= wp_q;
			ra_fs_s1 <= rp_fs_q;
			ra_na_s1 <= rp_na_q;
			ra_ns_s1 <= rp_ns_q;
		end
	end

	// ---------------- ring read stage ----------------
	gwdp_ring #(.DEPTH(RING_DEPTH), .WIDTH(SAMPLE_BITS), .ADDR_W(ADDR_W)) u_ring_fs (
		.clk(clk), .wr_en(adv1), .wr_addr(wa_s1), .wr_data(x_s1),
		.rd_en(adv1), .rd_addr(ra_fs_s1), .rd_data(rd_fs)
	);
	gwdp_ring #(.DEPTH(RING_DEPTH), .WIDTH(SAMPLE_BITS), .ADDR_W(ADDR_W)) u_ring_na (
		.clk(clk), .wr_en(adv1), .wr_addr(wa_s1), .wr_data(x_s1),
		.rd_en(adv1), .rd_addr(ra_na_s1), .rd_data(rd_na)
	);
	gwdp_ring #(.DEPTH(RING_DEPTH), .WIDTH(SAMPLE_BITS), .ADDR_W(ADDR_W)) u_ring_ns (
		.clk(clk), .wr_en(adv1), .wr_addr(wa_s1), .wr_data(x_s1),
		.rd_en(adv1), .rd_addr(ra_ns_s1), .rd_data(rd_ns)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv1) begin
			v2_q <= 1'b1;
		end else if (adv2) begin
			v2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s2     <= x_s1;
			last_s2  <= last_s1;
			flags_s2 <= flags_s1;
		end
	end

	// ---------------- sum stage ----------------
	logic signed [SUM_W-1:0]  far_new, near_new, sub_fs, add_na, sub_ns;
	logic signed [DIFF_W-1:0] diff, peak_new;
	logic                     have_new;

	always_comb begin
		sub_fs   = flags_s2.far_sub  ? SUM_W'(rd_fs) : '0;
		add_na   = flags_s2.near_add ? SUM_W'(rd_na) : '0;
		sub_ns   = flags_s2.near_sub ? SUM_W'(rd_ns) : '0;
		far_new  = far_sum_q + SUM_W'(x_s2) - sub_fs;
		near_new = near_sum_q + add_na - sub_ns;
		diff     = DIFF_W'(far_new) - DIFF_W'(near_new);
		peak_new = peak_q;
		have_new = have_peak_q;
		if (flags_s2.full && (!have_peak_q || diff > peak_q)) begin
			peak_new = diff;
			have_new = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_sum_q   <= '0;
			near_sum_q  <= '0;
			peak_q      <= '0;
			have_peak_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW_LEN || cfg_index == REG_GAP_LEN
					|| cfg_index == REG_INVERT_POLARITY) begin
				far_sum_q   <= '0;
				near_sum_q  <= '0;
				peak_q      <= '0;
				have_peak_q <= 1'b0;
			end
		end else if (adv2) begin
			if (last_s2) begin
				far_sum_q   <= '0;
				near_sum_q  <= '0;
				peak_q      <= '0;
				have_peak_q <= 1'b0;
			end else begin
				far_sum_q   <= far_new;
				near_sum_q  <= near_new;
				peak_q      <= peak_new;
				have_peak_q <= have_new;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (adv2 && res2) begin
			vo_q <= 1'b1;
		end else if (dout.ready) begin
			vo_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && res2) begin
			filter_value_q <= flags_s2.full ? OUT_W'(diff) : '0;
			filter_valid_q <= flags_s2.full;
			pulse_peak_q   <= (last_s2 && have_new) ? OUT_W'(peak_new) : '0;
			peak_valid_q   <= last_s2 && have_new;
			is_last_q      <= last_s2;
		end
	end

	assign dout.valid        = vo_q;
	assign dout.filter_value = filter_value_q;
	assign dout.filter_valid = filter_valid_q;
	assign dout.pulse_peak   = pulse_peak_q;
	assign dout.peak_valid   = peak_valid_q;
	assign dout.is_last      = is_last_q;

`ifndef SYNTHESIS
	a_peak_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.peak_valid |-> dout.is_last)
		else $error("peak reported on a result that does not close the pulse");

	a_result_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.filter_valid || dout.is_last))
		else $error("result with neither a full window nor a pulse end");

	a_pulse_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && last_s2 |=> (far_sum_q == '0) && (near_sum_q == '0) && !have_peak_q)
		else $error("pulse state not cleared after the closing transfer");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q <= LAST_ADDR) && (rp_fs_q <= LAST_ADDR) && (rp_na_q <= LAST_ADDR)
		&& (rp_ns_q <= LAST_ADDR))
		else $error("ring pointer beyond ring depth");
`endif

endmodule

// File: src/gwdp_ring.sv
// ----------------------------------------------------------------------------
// gwdp_ring
// Sample ring copy: one write port, one registered read port, write-first
// when both hit the same entry.
// ----------------------------------------------------------------------------
module gwdp_ring #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 10
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [ADDR_W-1:0]       wr_addr,
	input  logic signed [WIDTH-1:0] wr_data,
	input  logic                    rd_en,
	input  logic [ADDR_W-1:0]       rd_addr,
	output logic signed [WIDTH-1:0] rd_data
);

	logic signed [WIDTH-1:0] mem [DEPTH];
	logic signed [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			// distance that is a multiple of the depth reads the sample being written
			if (wr_en && (rd_addr == wr_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// File: dv/gwdp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwdp_checker
// Scoreboard for the gapped window difference peak filter. Mirrors the filter
// state on every sample transfer and every register write, queues the result
// each sample should give, and compares every result transfer against it.
// ----------------------------------------------------------------------------
module gwdp_checker
	import gwdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	gwdp_in_if                    din,
	gwdp_out_if                   dout,
	output int                    fail_count,
	output int                    pending
);
	localparam int RING_DEPTH = 1024;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int ACC_W      = OUT_W + 1;
	localparam int PRINT_MAX  = 100;

	typedef struct {
		logic signed [OUT_W-1:0] filter_value;
		logic                    filter_valid;
		logic signed [OUT_W-1:0] pulse_peak;
		logic                    peak_valid;
		logic                    is_last;
	} filter_result_t;

	filter_result_t expected_q[$];

	logic signed [15:0]      hist [RING_DEPTH];
	logic signed [ACC_W-1:0] near_acc;
	logic signed [ACC_W-1:0] far_acc;
	logic [COUNT_W-1:0]      seen;
	logic [PTR_W-1:0]        wr_ptr;
	logic signed [ACC_W-1:0] peak;
	logic                    peak_seen;
	logic [7:0]              win_len;
	logic [7:0]              gap;
	logic                    invert;

	task automatic report(input string msg);
		if (fail_count < PRINT_MAX)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic restart_pulse();
		near_acc  = '0;
		far_acc   = '0;
		seen      = '0;
		wr_ptr    = '0;
		peak      = '0;
		peak_seen = 1'b0;
	endtask

	// sample written d positions before wp; wraps around the ring
	function automatic logic signed [15:0] hist_back(input logic [PTR_W-1:0] wp, input int d);
		logic [PTR_W-1:0] idx;
		idx = wp - PTR_W'(d);
		return hist[idx];
	endfunction

	task automatic filter_sample(input logic signed [15:0] raw, input logic closes);
		logic signed [15:0]      x;
		logic signed [ACC_W-1:0] diff;
		logic [PTR_W-1:0]        wp;
		int                      n;
		int                      wl;
		int                      span;
		logic                    full;
		filter_result_t          r;
		// negating the most negative sample saturates
		if (invert)
			x = (raw == 16'sh8000) ? 16'sh7fff : -raw;
		else
			x = raw;
		n    = int'(seen);
		wl   = int'(win_len);
		span = 2 * wl + int'(gap);
		wp   = wr_ptr;
		hist[wp] = x;
		far_acc = far_acc + x;
		if (n >= wl + 1)
			far_acc = far_acc - hist_back(wp, wl + 1);
		// with zero window and zero gap this picks up the sample just written
		if (n >= wl + int'(gap))
			near_acc = near_acc + hist_back(wp, wl + int'(gap));
		if (n >= span + 1)
			near_acc = near_acc - hist_back(wp, span + 1);
		full = (n >= span);
		diff = far_acc - near_acc;
		if (full && (!peak_seen || diff > peak)) begin
			peak      = diff;
			peak_seen = 1'b1;
		end
		wr_ptr = wp + 1'b1;
		if (seen != COUNT_MAX)
			seen = seen + 1'b1;
		if (full || closes) begin
			r.filter_value = full ? diff[OUT_W-1:0] : '0;
			r.filter_valid = full;
			r.pulse_peak   = (closes && peak_seen) ? peak[OUT_W-1:0] : '0;
			r.peak_valid   = closes && peak_seen;
			r.is_last      = closes;
			expected_q.push_back(r);
		end
		if (closes)
			restart_pulse();
	endtask

	task automatic compare_result();
		filter_result_t e;
		if (expected_q.size() == 0) begin
			report($sformatf("result with nothing expected: value %0d last %0b",
				dout.filter_value, dout.is_last));
			return;
		end
		e = expected_q.pop_front();
		if (dout.filter_value !== e.filter_value)
			report($sformatf("filter_value got %0d expected %0d",
				dout.filter_value, e.filter_value));
		if (dout.filter_valid !== e.filter_valid)
			report($sformatf("filter_valid got %0b expected %0b",
				dout.filter_valid, e.filter_valid));
		if (dout.pulse_peak !== e.pulse_peak)
			report($sformatf("pulse_peak got %0d expected %0d",
				dout.pulse_peak, e.pulse_peak));
		if (dout.peak_valid !== e.peak_valid)
			report($sformatf("peak_valid got %0b expected %0b",
				dout.peak_valid, e.peak_valid));
		if (dout.is_last !== e.is_last)
			report($sformatf("is_last got %0b expected %0b", dout.is_last, e.is_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len = WINDOW_LEN_RST;
			gap     = GAP_LEN_RST;
			invert  = INVERT_POLARITY_RST;
			restart_pulse();
			expected_q.delete();
		end else begin
			// a write to any of the three registers restarts the pulse
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_LEN: begin
						win_len = cfg_data;
						restart_pulse();
					end
					REG_GAP_LEN: begin
						gap = cfg_data;
						restart_pulse();
					end
					REG_INVERT_POLARITY: begin
						invert = cfg_data[0];
						restart_pulse();
					end
					default: ;
				endcase
			end
			if (din.valid && din.ready)
				filter_sample(din.sample, din.pulse_end);
			if (dout.valid && dout.ready)
				compare_result();
		end
		pending = expected_q.size();
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the gapped window difference peak filter: directed extremes and
// short pulses, then random pulses over several window settings with random
// stalls on both channels in the first four. The checker does the scoring; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module testbench
	import gwdp_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int send_idle_pct = 38;
	int recv_idle_pct = 46;
	int fail_count;
	int pending;
	int quiet_cycles;

	gwdp_in_if  din ();
	gwdp_out_if dout ();

	gapped_window_difference_peak u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din),
		.dout      (dout)
	);

	gwdp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.din        (din),
		.dout       (dout),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		dout.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ends the run when neither channel has a transfer for too long
	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(32)) - 16'sd16;
			default: return 16'($urandom());
		endcase
	endfunction

	// entered and left just after a falling edge
	task automatic send_sample(input logic signed [15:0] s, input logic closes);
		while ($urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid     <= 1'b1;
		din.sample    <= s;
		din.pulse_end <= closes;
		do @(posedge clk); while (!din.ready);
		@(negedge clk);
	endtask

	// hold off until every queued result is out and the pipeline is empty
	task automatic drain();
		din.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic configure(input logic [7:0] wl, input logic [7:0] gp, input logic inv);
		drain();
		write_reg(REG_WINDOW_LEN, wl);
		write_reg(REG_GAP_LEN, gp);
		write_reg(REG_INVERT_POLARITY, {7'd0, inv});
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int wl, input int gp, input logic inv, input int n_items,
		input int fixed_len);
		int span;
		int left;
		int k;
		configure(8'(wl), 8'(gp), inv);
		span = 2 * wl + gp + 1;
		left = 0;
		for (k = 0; k < n_items; k++) begin
			if (left == 0) begin
				if (fixed_len != 0)
					left = fixed_len;
				else begin
					// mostly pulses that fill the span, some cut short
					case ($urandom_range(19))
						0, 1, 2: left = $urandom_range(span, 1);
						3: left = 1;
						default: left = span + $urandom_range(40);
					endcase
				end
			end
			if (k == n_items / 2 || $urandom_range(149) == 0)
				drain();
			send_sample(pick_sample(), left == 1);
			left--;
		end
	endtask

	initial begin
		din.valid     = 1'b0;
		din.sample    = '0;
		din.pulse_end = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: single-sample pulses close without a window
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7fff, 1'b1);

		drain();
		write_reg(REG_WINDOW_LEN, 8'd0);
		cfg_we <= 1'b0;
		// one-sample windows, gap and polarity still at reset
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd5, 1'b1);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd2, 1'b1);
		send_sample(16'sd7, 1'b0);
		send_sample(-16'sd7, 1'b0);
		send_sample(16'sd100, 1'b1);

		drain();
		write_reg(REG_INVERT_POLARITY, 8'd0);
		cfg_we <= 1'b0;
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		drain();
		send_sample(16'sd12345, 1'b0);
		send_sample(-16'sd12345, 1'b1);
		// pulse left open, the write below restarts it
		send_sample(16'sd3, 1'b0);
		send_sample(16'sd4, 1'b0);
		drain();
		write_reg(REG_GAP_LEN, 8'd0);
		cfg_we <= 1'b0;
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);

		run_phase(3, 2, 1'b1, 100, 0);
		run_phase(0, 0, 1'b0, 80, 0);

		send_idle_pct = 46;
		recv_idle_pct = 38;
		run_phase(1, 255, 1'b0, 270, 0);
		run_phase(7, 0, 1'b1, 60, 0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// widest windows: each sum covers 256 samples
		run_phase(255, 0, 1'b1, 530, 530);
		run_phase(0, 5, 1'b1, 60, 0);
		run_phase(50, 1, 1'b1, 120, 0);

		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
